FILE: rtl/tcu_pkg.sv
`timescale 1ns / 1ps
package tcu_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int MAX_RES       = 8;
   localparam int RES_CNT_W     = 4;

   localparam logic [31:0] ISN_RESET = 32'h1221_1221;
   localparam logic [31:0] ISN_STEP  = 32'h0000_0042;

   localparam logic [3:0] ST_CLOSED      = 4'd0;
   localparam logic [3:0] ST_SYN_RCVD    = 4'd2;
   localparam logic [3:0] ST_ESTABLISHED = 4'd4;
   localparam logic [3:0] ST_FIN_WAIT_1  = 4'd7;
   localparam logic [3:0] ST_TIME_WAIT   = 4'd10;

   localparam logic [5:0] F_FIN = 6'h01;
   localparam logic [5:0] F_SYN = 6'h02;
   localparam logic [5:0] F_ACK = 6'h10;

   localparam logic [2:0] ACT_SYN_ACK    = 3'd1;
   localparam logic [2:0] ACT_RST        = 3'd2;
   localparam logic [2:0] ACT_ACK        = 3'd3;
   localparam logic [2:0] ACT_FIN        = 3'd4;
   localparam logic [2:0] ACT_RETRANSMIT = 3'd5;
   localparam logic [2:0] ACT_CLOSED     = 3'd6;

   localparam logic [2:0] CSR_LISTEN_A    = 3'd0;
   localparam logic [2:0] CSR_LISTEN_B    = 3'd1;
   localparam logic [2:0] CSR_LISTEN_C    = 3'd2;
   localparam logic [2:0] CSR_LISTEN_D    = 3'd3;
   localparam logic [2:0] CSR_TIME_WAIT   = 3'd4;
   localparam logic [2:0] CSR_DEFAULT_MSS = 3'd5;
   localparam logic [2:0] CSR_MAX_RETRIES = 3'd6;

   localparam logic [15:0] LISTEN_A_RESET    = 16'd9;
   localparam logic [15:0] LISTEN_B_RESET    = 16'd7;
   localparam logic [15:0] LISTEN_C_RESET    = 16'd23;
   localparam logic [15:0] LISTEN_D_RESET    = 16'd80;
   localparam logic [15:0] TIME_WAIT_RESET   = 16'd3000;
   localparam logic [15:0] DEFAULT_MSS_RESET = 16'd420;
   localparam logic [2:0]  MAX_RETRIES_RESET = 3'd5;

   typedef struct packed {
      logic        mode;
      logic [31:0] src_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] seq_num;
      logic [31:0] ack_num;
      logic [5:0]  seg_flags;
      logic [15:0] payload_len;
      logic [15:0] peer_mss;
      logic [31:0] now_ticks;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [2:0]  slot;
      logic [31:0] dest_addr;
      logic [15:0] dest_port;
      logic [15:0] local_port_out;
      logic [31:0] seq_out;
      logic [31:0] ack_out;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] listen_a;
      logic [15:0] listen_b;
      logic [15:0] listen_c;
      logic [15:0] listen_d;
      logic [15:0] time_wait_ticks;
      logic [15:0] default_mss;
      logic [2:0]  max_retries;
   } cfg_type;

   typedef struct packed {
      req_type req;
      logic    is_tick;
      logic    syn;
      logic    ack_f;
      logic    fin;
      logic    listen;
   } item_type;

   typedef struct packed {
      logic [3:0]  state;
      logic [15:0] lport;
      logic [31:0] raddr;
      logic [15:0] rport;
      logic [31:0] rnext;
      logic [31:0] suna;
      logic [31:0] snext;
      logic [15:0] mss;
      logic [31:0] ctime;
      logic [2:0]  retry;
   } entry_type;

endpackage

FILE: rtl/tcu_req_if.sv
`timescale 1ns / 1ps
interface tcu_req_if import tcu_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/tcu_rsp_if.sv
`timescale 1ns / 1ps
interface tcu_rsp_if import tcu_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/tcu_front.sv
`timescale 1ns / 1ps
module tcu_front import tcu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   tcu_req_if.sink  req_bus,
   output item_type q_item,
   output logic     q_valid,
   input  logic     q_pop
);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           q_mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   item_type           item_in;
   logic               push, pop;

   assign req_bus.ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign q_valid       = (count_ff != '0);
   assign q_item        = q_mem_ff[rd_ptr_ff];
   assign push          = req_bus.valid && req_bus.ready;
   assign pop           = q_pop && q_valid;

   always_comb begin
      item_in         = '0;
      item_in.req     = req_bus.data;
      item_in.is_tick = req_bus.data.mode;
      item_in.syn     = (req_bus.data.seg_flags & F_SYN) != '0;
      item_in.ack_f   = (req_bus.data.seg_flags & F_ACK) != '0;
      item_in.fin     = (req_bus.data.seg_flags & F_FIN) != '0;
      item_in.listen  = (req_bus.data.dst_port != '0) &&
                        ((req_bus.data.dst_port == cfg.listen_a) ||
                         (req_bus.data.dst_port == cfg.listen_b) ||
                         (req_bus.data.dst_port == cfg.listen_c) ||
                         (req_bus.data.dst_port == cfg.listen_d));
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item_in;
      end
   end
endmodule

FILE: rtl/tcu_engine.sv
`timescale 1ns / 1ps
module tcu_engine import tcu_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  item_type  q_item,
   input  logic      q_valid,
   output logic      q_pop,
   tcu_rsp_if.source rsp_bus
);
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_SCAN   = 9'b000000010,
      S_SEG_A  = 9'b000000100,
      S_SEG_B  = 9'b000001000,
      S_EMIT0  = 9'b000010000,
      S_EMIT1  = 9'b000100000,
      S_OPEN   = 9'b001000000,
      S_TICK   = 9'b010000000,
      S_FINISH = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   hit_ff, hit_in;
   logic [IDX_W-1:0]   free_ff, free_in;
   logic               free_found_ff, free_found_in;
   item_type           item_ff, item_in;
   entry_type          entry_ff, entry_in;
   logic [31:0]        d_ff, d_in;
   logic [31:0]        w_ff, w_in;
   logic [31:0]        rn_ff, rn_in;
   rsp_type            seg_res_ff, seg_res_in;
   logic               has0_ff, has0_in, has1_ff, has1_in;
   logic [2:0]         act1_ff, act1_in;
   logic [RES_CNT_W-1:0] n_ff, n_in;
   logic [31:0]        isn_ff, isn_in;
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic               pend_v_ff, pend_v_in;
   rsp_type            pend_ff, pend_in;
   logic               out_v_ff, out_v_in;
   rsp_type            out_ff, out_in;

   entry_type          mem [SLOTS];
   entry_type          rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;

   logic               out_free, can_push;
   logic               emit, fin_req;
   rsp_type            emit_r;

   entry_type          e, ne;
   logic               match, active, expire, outst, go, ok, adv, plen_nz, end_walk;
   logic [31:0]        dd, age;

   assign out_free      = !out_v_ff || rsp_bus.ready;
   assign can_push      = !pend_v_ff || out_free;
   assign rsp_bus.valid = out_v_ff;
   assign rsp_bus.data  = out_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      free_in       = free_ff;
      free_found_in = free_found_ff;
      item_in       = item_ff;
      entry_in      = entry_ff;
      d_in          = d_ff;
      w_in          = w_ff;
      rn_in         = rn_ff;
      seg_res_in    = seg_res_ff;
      has0_in       = has0_ff;
      has1_in       = has1_ff;
      act1_in       = act1_ff;
      n_in          = n_ff;
      isn_in        = isn_ff;
      valid_in      = valid_ff;
      q_pop         = 1'b0;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_data_ff;
      emit          = 1'b0;
      fin_req       = 1'b0;
      emit_r        = '0;
      e             = rd_data_ff;
      ne            = entry_ff;
      match         = 1'b0;
      active        = 1'b0;
      expire        = 1'b0;
      outst         = 1'b0;
      go            = 1'b0;
      ok            = 1'b0;
      adv           = 1'b0;
      plen_nz       = item_ff.req.payload_len != '0;
      end_walk      = 1'b0;
      dd            = '0;
      age           = '0;

      case (state_ff)
         S_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               item_in       = q_item;
               idx_in        = '0;
               rd_addr       = '0;
               n_in          = '0;
               free_found_in = 1'b0;
               state_in      = q_item.is_tick ? S_TICK : S_SCAN;
            end
         end

         S_SCAN: begin
            match = valid_ff[idx_ff] && (e.lport == item_ff.req.dst_port) &&
                    (e.raddr == item_ff.req.src_addr) && (e.rport == item_ff.req.src_port);
            if (!valid_ff[idx_ff] && !free_found_ff) begin
               free_in       = idx_ff;
               free_found_in = 1'b1;
            end
            if (match) begin
               entry_in = e;
               hit_in   = idx_ff;
               state_in = S_SEG_A;
            end else if (idx_ff == LAST_IDX) begin
               state_in = item_ff.syn ? S_OPEN : S_FINISH;
            end else begin
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end

         S_SEG_A: begin
            d_in     = item_ff.req.ack_num - entry_ff.suna;
            w_in     = entry_ff.snext - entry_ff.suna;
            rn_in    = item_ff.req.seq_num + {16'b0, item_ff.req.payload_len} +
                       {31'b0, item_ff.fin};
            state_in = S_SEG_B;
         end

         S_SEG_B: begin
            ok  = item_ff.ack_f && (d_ff != '0) && !d_ff[31];
            dd  = (d_ff > w_ff) ? w_ff : d_ff;
            adv = ok && (dd != '0);
            if (adv) begin
               ne.suna  = entry_ff.suna + dd;
               ne.retry = '0;
               if (entry_ff.state == ST_SYN_RCVD) begin
                  ne.state = ST_ESTABLISHED;
                  ne.ctime = item_ff.req.now_ticks;
               end
            end
            if (plen_nz || item_ff.fin) begin
               ne.rnext = rn_ff;
            end
            has0_in = plen_nz;
            has1_in = 1'b0;
            act1_in = ACT_ACK;
            if (item_ff.fin) begin
               if ((ne.state == ST_FIN_WAIT_1) || (ne.state == ST_TIME_WAIT)) begin
                  if (ne.state == ST_FIN_WAIT_1) begin
                     ne.state = ST_TIME_WAIT;
                     ne.ctime = item_ff.req.now_ticks;
                  end
                  has1_in = !plen_nz;
               end else begin
                  has1_in  = 1'b1;
                  act1_in  = ACT_FIN;
                  ne.snext = entry_ff.snext + 1'b1;
                  ne.state = ST_FIN_WAIT_1;
                  ne.ctime = item_ff.req.now_ticks;
               end
            end
            seg_res_in                = '0;
            seg_res_in.slot           = 3'(hit_ff);
            seg_res_in.dest_addr      = entry_ff.raddr;
            seg_res_in.dest_port      = entry_ff.rport;
            seg_res_in.local_port_out = entry_ff.lport;
            seg_res_in.seq_out        = entry_ff.snext;
            seg_res_in.ack_out        = ne.rnext;
            wr_en    = 1'b1;
            wr_addr  = hit_ff;
            wr_data  = ne;
            state_in = S_EMIT0;
         end

         S_EMIT0: begin
            if (has0_ff) begin
               emit          = 1'b1;
               emit_r        = seg_res_ff;
               emit_r.action = ACT_ACK;
               if (can_push) begin
                  state_in = S_EMIT1;
               end
            end else begin
               state_in = S_EMIT1;
            end
         end

         S_EMIT1: begin
            if (has1_ff) begin
               emit          = 1'b1;
               emit_r        = seg_res_ff;
               emit_r.action = act1_ff;
               if (can_push) begin
                  state_in = S_FINISH;
               end
            end else begin
               state_in = S_FINISH;
            end
         end

         S_OPEN: begin
            emit                  = 1'b1;
            emit_r.dest_addr      = item_ff.req.src_addr;
            emit_r.dest_port      = item_ff.req.src_port;
            emit_r.local_port_out = item_ff.req.dst_port;
            emit_r.ack_out        = item_ff.req.seq_num + 1'b1;
            if (item_ff.listen && free_found_ff) begin
               emit_r.action  = ACT_SYN_ACK;
               emit_r.slot    = 3'(free_ff);
               emit_r.seq_out = isn_ff + ISN_STEP;
               wr_data.state  = ST_SYN_RCVD;
               wr_data.lport  = item_ff.req.dst_port;
               wr_data.raddr  = item_ff.req.src_addr;
               wr_data.rport  = item_ff.req.src_port;
               wr_data.rnext  = item_ff.req.seq_num + 1'b1;
               wr_data.suna   = isn_ff + ISN_STEP;
               wr_data.snext  = isn_ff + ISN_STEP + 32'd1;
               wr_data.mss    = (item_ff.req.peer_mss != '0) ? item_ff.req.peer_mss
                                                             : cfg.default_mss;
               wr_data.ctime  = item_ff.req.now_ticks;
               wr_data.retry  = '0;
               wr_addr        = free_ff;
               if (can_push) begin
                  wr_en             = 1'b1;
                  valid_in[free_ff] = 1'b1;
                  isn_in            = isn_ff + ISN_STEP;
               end
            end else begin
               emit_r.action  = ACT_RST;
               emit_r.slot    = '0;
               emit_r.seq_out = '0;
            end
            if (can_push) begin
               state_in = S_FINISH;
            end
         end

         S_TICK: begin
            age    = item_ff.req.now_ticks - e.ctime;
            active = valid_ff[idx_ff] && (e.state != ST_CLOSED);
            expire = (e.state == ST_TIME_WAIT) && (age > {16'b0, cfg.time_wait_ticks});
            outst  = e.suna != e.snext;
            go     = active && (expire || outst);
            emit_r.slot           = 3'(idx_ff);
            emit_r.dest_addr      = e.raddr;
            emit_r.dest_port      = e.rport;
            emit_r.local_port_out = e.lport;
            emit_r.ack_out        = e.rnext;
            wr_data = e;
            if (expire) begin
               emit_r.action  = ACT_CLOSED;
               emit_r.seq_out = '0;
               emit_r.ack_out = '0;
               wr_data.state  = ST_CLOSED;
            end else if (e.retry >= cfg.max_retries) begin
               emit_r.action  = ACT_FIN;
               emit_r.seq_out = e.snext;
               wr_data.state  = ST_TIME_WAIT;
               wr_data.ctime  = item_ff.req.now_ticks;
               wr_data.snext  = e.snext + 1'b1;
               wr_data.suna   = e.snext + 1'b1;
               wr_data.retry  = '0;
            end else begin
               emit_r.action  = ACT_RETRANSMIT;
               emit_r.seq_out = e.suna;
               wr_data.retry  = (e.retry == 3'd7) ? e.retry : e.retry + 1'b1;
            end
            emit = go;
            if (go && !can_push) begin
               rd_addr = idx_ff;
            end else begin
               if (go) begin
                  wr_en = 1'b1;
                  n_in  = n_ff + 1'b1;
                  if (expire) begin
                     valid_in[idx_ff] = 1'b0;
                  end
               end
               end_walk = (idx_ff == LAST_IDX) ||
                          (go && (n_ff + 1'b1 == RES_CNT_W'(MAX_RES)));
               if (end_walk) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end

         S_FINISH: begin
            fin_req = 1'b1;
            if (can_push) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_v_in  = out_v_ff && !rsp_bus.ready;
      out_in    = out_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      if (emit && can_push) begin
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_in      = pend_ff;
            out_in.last = 1'b0;
         end
         pend_v_in = 1'b1;
         pend_in   = emit_r;
      end
      if (fin_req && pend_v_ff && out_free) begin
         out_v_in    = 1'b1;
         out_in      = pend_ff;
         out_in.last = 1'b1;
         pend_v_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         isn_ff    <= ISN_RESET;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         isn_ff    <= isn_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      free_ff       <= free_in;
      free_found_ff <= free_found_in;
      item_ff       <= item_in;
      entry_ff      <= entry_in;
      d_ff          <= d_in;
      w_ff          <= w_in;
      rn_ff         <= rn_in;
      seg_res_ff    <= seg_res_in;
      has0_ff       <= has0_in;
      has1_ff       <= has1_in;
      act1_ff       <= act1_in;
      n_ff          <= n_in;
      pend_ff       <= pend_in;
      out_ff        <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule

FILE: rtl/tcp_connection_table_unit.sv
`timescale 1ns / 1ps
// The engine handles one request at a time and walks the slot table slot by slot: a
//   segment walk stops at the matching slot, an open or refusal follows a full walk, and a
//   tick walks to the last slot or until MAX_RES results; any output stall holds it further.
//   A two-entry queue takes requests while the engine is busy.
// Reset: synchronous, active high; clears slot valid bits and queue, reloads ISN and config
//   registers with their start values.
module tcp_connection_table_unit import tcu_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   tcu_req_if.sink     req_bus,
   tcu_rsp_if.source   rsp_bus,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wr_data
);
   cfg_type  cfg_ff, cfg_in;
   item_type q_item;
   logic     q_valid, q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LISTEN_A:    cfg_in.listen_a        = csr_wr_data;
            CSR_LISTEN_B:    cfg_in.listen_b        = csr_wr_data;
            CSR_LISTEN_C:    cfg_in.listen_c        = csr_wr_data;
            CSR_LISTEN_D:    cfg_in.listen_d        = csr_wr_data;
            CSR_TIME_WAIT:   cfg_in.time_wait_ticks = csr_wr_data;
            CSR_DEFAULT_MSS: cfg_in.default_mss     = csr_wr_data;
            CSR_MAX_RETRIES: cfg_in.max_retries     = csr_wr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.listen_a        <= LISTEN_A_RESET;
         cfg_ff.listen_b        <= LISTEN_B_RESET;
         cfg_ff.listen_c        <= LISTEN_C_RESET;
         cfg_ff.listen_d        <= LISTEN_D_RESET;
         cfg_ff.time_wait_ticks <= TIME_WAIT_RESET;
         cfg_ff.default_mss     <= DEFAULT_MSS_RESET;
         cfg_ff.max_retries     <= MAX_RETRIES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcu_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .req_bus (req_bus),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   tcu_engine #(
      .SLOTS (SLOTS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );
endmodule

FILE: tb/tb_tcp_connection_table_unit.sv
`timescale 1ns / 1ps
module tb_tcp_connection_table_unit;
   import tcu_pkg::*;

   localparam int NSLOT      = SLOTS_DEFAULT;
   localparam int SETTLE     = 80;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } row_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_wr_data;

   tcu_req_if req_bus ();
   tcu_rsp_if rsp_bus ();

   tcp_connection_table_unit uut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   // shadow configuration
   logic [15:0] lp_a, lp_b, lp_c, lp_d, tw_ticks, dflt_mss;
   logic [2:0]  retry_max;

   // shadow connection table
   bit          c_valid [NSLOT];
   logic [3:0]  c_state [NSLOT];
   logic [15:0] c_lport [NSLOT];
   logic [31:0] c_raddr [NSLOT];
   logic [15:0] c_rport [NSLOT];
   logic [31:0] c_rnext [NSLOT];
   logic [31:0] c_suna  [NSLOT];
   logic [31:0] c_snext [NSLOT];
   logic [15:0] c_mss   [NSLOT];
   logic [31:0] c_ctime [NSLOT];
   logic [2:0]  c_retry [NSLOT];
   logic [31:0] isn;

   rsp_type segs_due[$];
   rsp_type step_out[$];
   bit      typed_pend;
   rsp_type typed_rsp;

   int errors, n_req, n_rsp, idle_cnt, hold_reqs;
   int act_seen [8];
   logic [31:0] now_t;
   logic [31:0] addr_pool [4];
   logic [15:0] port_pool [4];

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic void emit(logic [2:0] act, logic [2:0] s, logic [31:0] a,
                                logic [15:0] rp, logic [15:0] lp,
                                logic [31:0] sq, logic [31:0] ak);
      rsp_type o;
      o = '{action: act, slot: s, dest_addr: a, dest_port: rp, local_port_out: lp,
            seq_out: sq, ack_out: ak, last: 1'b0};
      step_out.push_back(o);
   endfunction

   function automatic void emit_slot(logic [2:0] act, int i, logic [31:0] sq, logic [31:0] ak);
      emit(act, i[2:0], c_raddr[i], c_rport[i], c_lport[i], sq, ak);
   endfunction

   function automatic bit is_listening(logic [15:0] p);
      return p != 0 && (p == lp_a || p == lp_b || p == lp_c || p == lp_d);
   endfunction

   function automatic int find_conn(logic [31:0] a, logic [15:0] sp, logic [15:0] dp);
      for (int i = 0; i < NSLOT; i++)
         if (c_valid[i] && c_lport[i] == dp && c_raddr[i] == a && c_rport[i] == sp) return i;
      return -1;
   endfunction

   function automatic void table_tick(logic [31:0] now);
      for (int i = 0; i < NSLOT && step_out.size() < MAX_RES; i++) begin
         if (!c_valid[i] || c_state[i] == ST_CLOSED) continue;
         if (c_state[i] == ST_TIME_WAIT && (now - c_ctime[i]) > {16'd0, tw_ticks}) begin
            c_valid[i] = 0;
            c_state[i] = ST_CLOSED;
            emit_slot(ACT_CLOSED, i, 0, 0);
            continue;
         end
         if (c_suna[i] != c_snext[i]) begin
            if (c_retry[i] >= retry_max) begin
               c_state[i] = ST_TIME_WAIT;
               c_ctime[i] = now;
               emit_slot(ACT_FIN, i, c_snext[i], c_rnext[i]);
               c_snext[i] = c_snext[i] + 1;
               c_suna[i] = c_snext[i];
               c_retry[i] = 0;
            end else begin
               if (c_retry[i] < 7) c_retry[i]++;
               emit_slot(ACT_RETRANSMIT, i, c_suna[i], c_rnext[i]);
            end
         end
      end
   endfunction

   function automatic void table_open(req_type r);
      int f;
      f = -1;
      for (int i = 0; i < NSLOT; i++)
         if (!c_valid[i]) begin
            f = i;
            break;
         end
      if (!is_listening(r.dst_port) || f < 0) begin
         emit(ACT_RST, 3'd0, r.src_addr, r.src_port, r.dst_port, 0, r.seq_num + 1);
         return;
      end
      c_valid[f] = 1;
      c_lport[f] = r.dst_port;
      c_raddr[f] = r.src_addr;
      c_rport[f] = r.src_port;
      c_rnext[f] = r.seq_num + 1;
      isn = isn + ISN_STEP;
      c_suna[f] = isn;
      c_snext[f] = isn + 1;
      c_mss[f] = r.peer_mss != 0 ? r.peer_mss : dflt_mss;
      c_state[f] = ST_SYN_RCVD;
      c_ctime[f] = r.now_ticks;
      c_retry[f] = 0;
      emit_slot(ACT_SYN_ACK, f, isn, c_rnext[f]);
   endfunction

   function automatic void table_segment(int i, req_type r);
      bit acked;
      logic [31:0] d, w;
      bit fin;
      acked = 0;
      fin = (r.seg_flags & F_FIN) != 0;
      if ((r.seg_flags & F_ACK) != 0) begin
         d = r.ack_num - c_suna[i];
         w = c_snext[i] - c_suna[i];
         if (d != 0 && d < 32'h8000_0000) begin
            if (d > w) d = w;
            if (d != 0) begin
               c_suna[i] = c_suna[i] + d;
               c_retry[i] = 0;
               if (c_state[i] == ST_SYN_RCVD) begin
                  c_state[i] = ST_ESTABLISHED;
                  c_ctime[i] = r.now_ticks;
               end
            end
         end
      end
      if (r.payload_len > 0 || fin) c_rnext[i] = r.seq_num + r.payload_len + fin;
      if (r.payload_len > 0) begin
         emit_slot(ACT_ACK, i, c_snext[i], c_rnext[i]);
         acked = 1;
      end
      if (fin) begin
         if (c_state[i] == ST_FIN_WAIT_1 || c_state[i] == ST_TIME_WAIT) begin
            if (c_state[i] == ST_FIN_WAIT_1) begin
               c_state[i] = ST_TIME_WAIT;
               c_ctime[i] = r.now_ticks;
            end
            if (!acked) emit_slot(ACT_ACK, i, c_snext[i], c_rnext[i]);
         end else begin
            emit_slot(ACT_FIN, i, c_snext[i], c_rnext[i]);
            c_snext[i] = c_snext[i] + 1;
            c_state[i] = ST_FIN_WAIT_1;
            c_ctime[i] = r.now_ticks;
         end
      end
   endfunction

   function automatic void predict_request(req_type r);
      int hit;
      step_out.delete();
      if (r.mode) table_tick(r.now_ticks);
      else begin
         hit = find_conn(r.src_addr, r.src_port, r.dst_port);
         if (hit >= 0) table_segment(hit, r);
         else if ((r.seg_flags & F_SYN) != 0) table_open(r);
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
   endfunction

   // request and result monitor
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && req_bus.valid && req_bus.ready) begin
         predict_request(req_bus.data);
         n_req++;
         if (typed_pend) begin
            if (step_out.size() != 1) begin
               errors++;
               $error("typed row: predictor gave %0d segments", step_out.size());
            end
            segs_due.push_back(typed_rsp);
            typed_pend = 0;
         end else
            foreach (step_out[k]) segs_due.push_back(step_out[k]);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.data;
         n_rsp++;
         act_seen[got.action]++;
         if (segs_due.size() == 0) begin
            errors++;
            $error("unexpected segment action %0d slot %0d", got.action, got.slot);
         end else begin
            want = segs_due.pop_front();
            if (got.action !== want.action) begin
               errors++; $error("action exp %0d got %0d", want.action, got.action);
            end
            if (got.slot !== want.slot) begin
               errors++; $error("slot exp %0d got %0d", want.slot, got.slot);
            end
            if (got.dest_addr !== want.dest_addr) begin
               errors++; $error("dest_addr exp %h got %h", want.dest_addr, got.dest_addr);
            end
            if (got.dest_port !== want.dest_port) begin
               errors++; $error("dest_port exp %h got %h", want.dest_port, got.dest_port);
            end
            if (got.local_port_out !== want.local_port_out) begin
               errors++;
               $error("local_port_out exp %h got %h", want.local_port_out, got.local_port_out);
            end
            if (got.seq_out !== want.seq_out) begin
               errors++; $error("seq_out exp %h got %h", want.seq_out, got.seq_out);
            end
            if (got.ack_out !== want.ack_out) begin
               errors++; $error("ack_out exp %h got %h", want.ack_out, got.ack_out);
            end
            if (got.last !== want.last) begin
               errors++; $error("last exp %0d got %0d", want.last, got.last);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cnt <= 0;
      else if (idle_cnt >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else
         idle_cnt <= idle_cnt + 1;
   end

   // result receiver: own stall pattern plus long hold-offs on request
   initial rsp_bus.ready = 1'b0;
   always @(negedge clock) begin
      int cyc, hold, seen, style;
      cyc++;
      if (cyc % 64 == 0) style = $urandom_range(0, 2);
      if (hold_reqs != seen) begin
         seen = hold_reqs;
         hold = 400;
      end
      if (hold > 0) begin
         hold--;
         rsp_bus.ready <= 1'b0;
      end else if (style == 0)
         rsp_bus.ready <= 1'b1;
      else if (style == 1)
         rsp_bus.ready <= $urandom_range(0, 1);
      else
         rsp_bus.ready <= ($urandom_range(0, 3) == 0);
   end

   int burst_left;

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(req_type r);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 30);
      end
      burst_left--;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data <= r;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (segs_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // leaves the write enable high; the caller drops it after the last write
   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      case (idx)
         CSR_LISTEN_A:    lp_a = val;
         CSR_LISTEN_B:    lp_b = val;
         CSR_LISTEN_C:    lp_c = val;
         CSR_LISTEN_D:    lp_d = val;
         CSR_TIME_WAIT:   tw_ticks = val;
         CSR_DEFAULT_MSS: dflt_mss = val;
         CSR_MAX_RETRIES: retry_max = val[2:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d,
                             logic [15:0] tw, logic [15:0] mss, logic [15:0] rt);
      write_csr(CSR_LISTEN_A, a);
      write_csr(CSR_LISTEN_B, b);
      write_csr(CSR_LISTEN_C, c);
      write_csr(CSR_LISTEN_D, d);
      write_csr(CSR_TIME_WAIT, tw);
      write_csr(CSR_DEFAULT_MSS, mss);
      write_csr(CSR_MAX_RETRIES, rt);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic req_type seg(logic [31:0] a, logic [15:0] sp, logic [15:0] dp,
                                   logic [31:0] sq, logic [31:0] ak, logic [5:0] fl,
                                   logic [15:0] len, logic [15:0] mss, logic [31:0] now);
      req_type r;
      r = '{mode: 1'b0, src_addr: a, src_port: sp, dst_port: dp, seq_num: sq, ack_num: ak,
            seg_flags: fl, payload_len: len, peer_mss: mss, now_ticks: now};
      return r;
   endfunction

   function automatic req_type tick(logic [31:0] now);
      req_type r;
      r = seg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, now);
      r.mode = 1'b1;
      return r;
   endfunction

   function automatic logic [15:0] pick_listen();
      case ($urandom_range(0, 4))
         0: return lp_a;
         1: return lp_b;
         2: return lp_c;
         3: return lp_d;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      int m, pick;
      logic [5:0] fl;
      pick = $urandom_range(0, 99);
      now_t = now_t + ($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 2000));
      if (pick < 5) begin
         r = tick(now_t);
         r.mode = 1'b0;
         return r;
      end
      if (pick < 18) return tick(now_t);
      r = seg(addr_pool[$urandom_range(0, 3)], port_pool[$urandom_range(0, 3)], pick_listen(),
              $urandom, $urandom, $urandom, 0, $urandom_range(0, 1) ? 16'd0 : 16'($urandom),
              now_t);
      m = find_conn(r.src_addr, r.src_port, r.dst_port);
      if (m < 0) begin
         if ($urandom_range(0, 9) < 8) r.seg_flags = (r.seg_flags & ~F_FIN) | F_SYN;
         return r;
      end
      fl = F_ACK | ($urandom_range(0, 4) == 0 ? F_FIN : 6'd0) | ($urandom & 6'h2c);
      if ($urandom_range(0, 9) == 0) fl = $urandom;
      r.seg_flags = fl;
      case ($urandom_range(0, 4))
         0: r.ack_num = $urandom;
         1: r.ack_num = c_suna[m];
         default: r.ack_num = c_snext[m] - $urandom_range(0, 1);
      endcase
      r.seq_num = $urandom_range(0, 7) == 0 ? 32'($urandom) : c_rnext[m];
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: r.payload_len = 0;
         5: r.payload_len = 16'hFFFF;
         default: r.payload_len = $urandom_range(1, 1500);
      endcase
      return r;
   endfunction

   initial begin
      row_type rows[$];
      row_type rw;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_LISTEN_A;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      now_t = 32'd100;
      lp_a = LISTEN_A_RESET; lp_b = LISTEN_B_RESET; lp_c = LISTEN_C_RESET;
      lp_d = LISTEN_D_RESET; tw_ticks = TIME_WAIT_RESET; dflt_mss = DEFAULT_MSS_RESET;
      retry_max = MAX_RETRIES_RESET;
      isn = ISN_RESET;
      for (int i = 0; i < NSLOT; i++) begin
         c_valid[i] = 0; c_state[i] = ST_CLOSED; c_lport[i] = 0; c_raddr[i] = 0;
         c_rport[i] = 0; c_rnext[i] = 0; c_suna[i] = 0; c_snext[i] = 0; c_mss[i] = 0;
         c_ctime[i] = 0; c_retry[i] = 0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: open at the extremes, refusals, data, close handshake, ticks
      rw.typed = 1;
      rw.req = seg('1, '1, 16'd80, '1, 0, F_SYN, 0, 0, 0);
      rw.rsp = '{ACT_SYN_ACK, 3'd0, '1, '1, 16'd80, ISN_RESET + ISN_STEP, 32'd0, 1'b1};
      rows.push_back(rw);
      rw.req = seg(0, 0, 16'd81, 32'd5, 0, F_SYN, 0, 0, 0);
      rw.rsp = '{ACT_RST, 3'd0, 32'd0, 16'd0, 16'd81, 32'd0, 32'd6, 1'b1};
      rows.push_back(rw);
      rw.req = seg(32'h0a000001, 16'd1234, 16'd0, '1, 0, F_SYN, 0, 0, 0);
      rw.rsp = '{ACT_RST, 3'd0, 32'h0a000001, 16'd1234, 16'd0, 32'd0, 32'd0, 1'b1};
      rows.push_back(rw);
      rw.typed = 0;
      rw.req = seg('1, '1, 16'd80, 0, ISN_RESET + ISN_STEP + 1, 6'h3c, 0, 0, 10);
      rows.push_back(rw);
      rw.req = seg('1, '1, 16'd80, 0, '1, F_ACK, 16'hFFFF, 0, 11);
      rows.push_back(rw);
      rw.req = seg(32'h01020304, 16'd5, 16'd80, 0, 0, F_ACK | F_FIN, 16'd10, 0, 12);
      rows.push_back(rw);
      rw.req = seg('1, '1, 16'd80, 32'h0000FFFF, 0, F_FIN, 0, 0, 13);
      rows.push_back(rw);
      rw.req = seg('1, '1, 16'd80, 32'h00010000, 0, F_FIN, 0, 0, 14);
      rows.push_back(rw);
      rw.req = seg('1, '1, 16'd80, 32'h00010001, 0, F_FIN | F_ACK, 16'd4, 0, 15);
      rows.push_back(rw);
      rw.req = tick(32'd100);
      rows.push_back(rw);
      rw.req = tick('1);
      rows.push_back(rw);
      for (int k = 0; k < NSLOT; k++) begin
         rw.req = seg(32'hc0a80001, 16'(k + 1), 16'd7, 32'(k * 1000), 0, F_SYN, 0,
                      k == 0 ? 16'hFFFF : 16'(k), 20);
         rows.push_back(rw);
      end
      rw.typed = 1;
      rw.req = seg(32'hc0a80002, 16'd99, 16'd9, 32'd77, 0, F_SYN, 0, 0, 21);
      rw.rsp = '{ACT_RST, 3'd0, 32'hc0a80002, 16'd99, 16'd9, 32'd0, 32'd78, 1'b1};
      rows.push_back(rw);
      rw.typed = 0;
      for (int k = 0; k < 6; k++) begin
         rw.req = tick(32'(30 + k));
         rows.push_back(rw);
      end
      foreach (rows[k]) begin
         typed_pend = rows[k].typed;
         typed_rsp = rows[k].rsp;
         send_request(rows[k].req);
      end
      drain();

      // random phases: phase 0 runs under the reset configuration, phases 1 to 4 each load one
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            1: set_config('1, 16'd0, 16'd1, 16'd80, 16'd0, '1, 16'd1);
            2: set_config($urandom, $urandom, 16'd0, 16'd0, '1, 16'd1, 16'hFFFF);
            3: set_config($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 4000),
                          $urandom, $urandom_range(1, 7));
            4: set_config(LISTEN_A_RESET, LISTEN_B_RESET, LISTEN_C_RESET, LISTEN_D_RESET,
                          TIME_WAIT_RESET, DEFAULT_MSS_RESET, MAX_RETRIES_RESET);
            default: ;
         endcase
         addr_pool[0] = 0;
         addr_pool[1] = '1;
         addr_pool[2] = $urandom;
         addr_pool[3] = $urandom;
         port_pool[0] = 0;
         port_pool[1] = '1;
         port_pool[2] = $urandom;
         port_pool[3] = $urandom;
         if (ph == 2) hold_reqs++;
         for (int k = 0; k < 100; k++) send_request(random_request());
         drain();
      end

      $display("Sent %0d requests (directed and 5 configurations), checked %0d segments",
               n_req, n_rsp);
      $display("Segments by action: synack %0d rst %0d ack %0d fin %0d retx %0d closed %0d",
               act_seen[ACT_SYN_ACK], act_seen[ACT_RST], act_seen[ACT_ACK],
               act_seen[ACT_FIN], act_seen[ACT_RETRANSMIT], act_seen[ACT_CLOSED]);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
